// ----- rtl/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the rv32 integer execute core: opcode and
// funct codes, data memory depth, register file write port and result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

    // word-indexed data memory depth seen by stores
    localparam logic [31:0] DMEM_DEPTH = 32'd1024;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    // major opcodes
    localparam logic [6:0] OPC_R     = 7'b0110011;
    localparam logic [6:0] OPC_I     = 7'b0010011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC = 7'b0010111;

    // funct3 codes of the alu group
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // highest legal store width code (sw)
    localparam logic [2:0] F3_STORE_MAX = 3'd2;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    // imm[11:10] selector of shift-right immediates
    localparam logic [1:0] SRI_LOGIC = 2'b00;
    localparam logic [1:0] SRI_ARITH = 2'b01;

    localparam logic [4:0] REG_ZERO = 5'd0;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_write_t;

    typedef struct packed {
        logic              reg_written;
        logic [REG_AW-1:0] dest_reg;
        logic [XLEN-1:0]   write_value;
        logic              store_valid;
        logic [XLEN-1:0]   store_index;
        logic [XLEN-1:0]   store_data;
        logic              store_out_of_range;
        logic              hazard_stall;
        logic              illegal_instr;
    } exec_result_t;

endpackage

`default_nettype wire

// ----- rtl/rv32_integer_execute_core.sv -----
// ----------------------------------------------------------------------------
// rv32_integer_execute_core
// One-instruction-per-transfer rv32 integer execute core with a 32-entry
// register file, store request output and hazard/illegal flags.
// ----------------------------------------------------------------------------
// usage
//  - s_axis carries one 32-bit instruction word per transfer
//  - m_axis returns exactly one result record per instruction, in order
//  - a word and its register file read data are captured when the word is
//    accepted, then execute moves into the result register once that is free
//  - throughput: one instruction per cycle, back to back, while m_axis_tready
//    is high; a word may use the register written by the word just before
//    it (bypass in the file)
//  - the critical path is register file read data through the alu or the
//    32x32 multiplier (low word) into the result register
//  - when m_axis_tready is low the result register holds, the execute stage
//    holds behind it and s_axis_tready drops only once both are full
//  - rst_n clears all registers to zero (per-entry valid bits, no sweep),
//    the hazard history and every valid flag
//  - a store is not performed here: index and data go out for the data
//    memory, with store_out_of_range set when the index is past its depth
// ----------------------------------------------------------------------------
`default_nettype none

module rv32_integer_execute_core
    import rvx_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] instr_word
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] reg_written, [5:1] dest_reg, [37:6] write_value, [38] store_valid,
    // [70:39] store_index, [102:71] store_data, [103] store_out_of_range,
    // [104] hazard_stall, [105] illegal_instr, [111:106] zero
    output logic [111:0]      m_axis_tdata
);

    logic              in_xfer;
    logic              advance;

    // execute stage
    logic              exec_valid_reg;
    logic              exec_valid_next;
    logic [XLEN-1:0]   instr_reg;
    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;

    // hazard history: whether the last retired instruction wrote, and its destination
    logic              last_wrote_reg;
    logic              last_wrote_next;
    logic [REG_AW-1:0] last_dest_reg;
    logic [REG_AW-1:0] last_dest_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    exec_result_t      out_reg;
    exec_result_t      exec_res;
    rf_write_t         rf_wr;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign advance       = exec_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !exec_valid_reg || advance;

    // the instruction retires into the result register and writes back together
    assign rf_wr.en   = advance && exec_res.reg_written;
    assign rf_wr.addr = exec_res.dest_reg;
    assign rf_wr.data = exec_res.write_value;

    rvx_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_xfer),
        .rd_addr1 (s_axis_tdata[19:15]),
        .rd_addr2 (s_axis_tdata[24:20]),
        .wr       (rf_wr),
        .rd_data1 (op_a),
        .rd_data2 (op_b)
    );

    rvx_execute u_execute (
        .instr      (instr_reg),
        .op_a       (op_a),
        .op_b       (op_b),
        .last_wrote (last_wrote_reg),
        .last_dest  (last_dest_reg),
        .result     (exec_res)
    );

    always_comb
    begin
        exec_valid_next = exec_valid_reg;
        if (in_xfer)
        begin
            exec_valid_next = 1'b1;
        end
        else if (advance)
        begin
            exec_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        last_wrote_next = last_wrote_reg;
        last_dest_next  = last_dest_reg;
        if (advance)
        begin
            last_wrote_next = exec_res.reg_written;
            last_dest_next  = exec_res.dest_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_wrote_reg <= 1'b0;
            last_dest_reg  <= REG_ZERO;
        end
        else
        begin
            exec_valid_reg <= exec_valid_next;
            out_valid_reg  <= out_valid_next;
            last_wrote_reg <= last_wrote_next;
            last_dest_reg  <= last_dest_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            instr_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_reg <= exec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            out_reg.illegal_instr,
                            out_reg.hazard_stall,
                            out_reg.store_out_of_range,
                            out_reg.store_data,
                            out_reg.store_index,
                            out_reg.store_valid,
                            out_reg.write_value,
                            out_reg.dest_reg,
                            out_reg.reg_written};

endmodule

`default_nettype wire

// ----- rtl/rvx_regfile.sv -----
// ----------------------------------------------------------------------------
// rvx_regfile
// 32-entry integer register file, one write and two registered read ports,
// per-entry valid bits for the all-zero reset and write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_regfile
    import rvx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [REG_AW-1:0] rd_addr1,
    input  wire logic [REG_AW-1:0] rd_addr2,
    input  wire rf_write_t         wr,
    output logic [XLEN-1:0]        rd_data1,
    output logic [XLEN-1:0]        rd_data2
);

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [XLEN-1:0]      rd_data1_reg;
    logic [XLEN-1:0]      rd_data2_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // a write in the same cycle wins over the stored copy
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && wr.addr == rd_addr1)
            begin
                rd_data1_reg <= wr.data;
            end
            else
            begin
                rd_data1_reg <= valid_reg[rd_addr1] ? mem[rd_addr1] : '0;
            end
            if (wr.en && wr.addr == rd_addr2)
            begin
                rd_data2_reg <= wr.data;
            end
            else
            begin
                rd_data2_reg <= valid_reg[rd_addr2] ? mem[rd_addr2] : '0;
            end
        end
    end

    assign rd_data1 = rd_data1_reg;
    assign rd_data2 = rd_data2_reg;

endmodule

`default_nettype wire

// ----- rtl/rvx_execute.sv -----
// ----------------------------------------------------------------------------
// rvx_execute
// Decode and execute of one instruction: alu, multiply low word, lui/auipc,
// store address and data, hazard and illegal flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_execute
    import rvx_pkg::*;
(
    input  wire logic [XLEN-1:0]   instr,
    input  wire logic [XLEN-1:0]   op_a,
    input  wire logic [XLEN-1:0]   op_b,
    input  wire logic              last_wrote,
    input  wire logic [REG_AW-1:0] last_dest,
    output exec_result_t           result
);

    logic [6:0]        opc;
    logic [REG_AW-1:0] rd;
    logic [2:0]        f3;
    logic [REG_AW-1:0] rs1;
    logic [REG_AW-1:0] rs2;
    logic [6:0]        f7;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_s;
    logic [4:0]        shamt;
    logic [XLEN-1:0]   mul_lo;
    logic [XLEN-1:0]   sidx;
    logic [XLEN-1:0]   val;
    logic              illegal;
    logic              writes;
    logic              is_store;
    logic              reads1;
    logic              reads2;
    logic              wrote;
    logic              stall;

    assign opc   = instr[6:0];
    assign rd    = instr[11:7];
    assign f3    = instr[14:12];
    assign rs1   = instr[19:15];
    assign rs2   = instr[24:20];
    assign f7    = instr[31:25];
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    // register shifts take rs2 low bits, immediate shifts imm[4:0]
    assign shamt = (opc == OPC_R) ? op_b[4:0] : instr[24:20];
    assign mul_lo = op_a * op_b;
    assign sidx   = op_a + imm_s;

    always_comb
    begin
        val      = '0;
        illegal  = 1'b0;
        writes   = 1'b0;
        is_store = 1'b0;
        reads1   = 1'b0;
        reads2   = 1'b0;
        case (opc)
            OPC_R:
            begin
                reads1 = 1'b1;
                reads2 = 1'b1;
                writes = 1'b1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  val = op_a + op_b;
                        F3_SLL:  val = op_a << shamt;
                        F3_SLT:  val = {31'd0, $signed(op_a) < $signed(op_b)};
                        F3_SLTU: val = {31'd0, op_a < op_b};
                        F3_XOR:  val = op_a ^ op_b;
                        F3_SR:   val = op_a >> shamt;
                        F3_OR:   val = op_a | op_b;
                        default: val = op_a & op_b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                begin
                    val = op_a - op_b;
                end
                else if (f7 == F7_ALT && f3 == F3_SR)
                begin
                    val = $unsigned($signed(op_a) >>> shamt);
                end
                else if (f7 == F7_MUL && f3 == F3_ADD)
                begin
                    val = mul_lo;
                end
                else
                begin
                    illegal = 1'b1;
                end
            end
            OPC_I:
            begin
                reads1 = 1'b1;
                writes = 1'b1;
                case (f3)
                    F3_ADD:  val = op_a + imm_i;
                    F3_SLL:  val = op_a << shamt;
                    F3_SLT:  val = {31'd0, $signed(op_a) < $signed(imm_i)};
                    F3_SLTU: val = {31'd0, op_a < imm_i};
                    F3_XOR:  val = op_a ^ imm_i;
                    F3_SR:
                    begin
                        if (instr[31:30] == SRI_LOGIC)
                        begin
                            val = op_a >> shamt;
                        end
                        else if (instr[31:30] == SRI_ARITH)
                        begin
                            val = $unsigned($signed(op_a) >>> shamt);
                        end
                        else
                        begin
                            illegal = 1'b1;
                        end
                    end
                    F3_OR:   val = op_a | imm_i;
                    default: val = op_a & imm_i;
                endcase
            end
            OPC_STORE:
            begin
                if (f3 > F3_STORE_MAX)
                begin
                    illegal = 1'b1;
                end
                else
                begin
                    reads1   = 1'b1;
                    reads2   = 1'b1;
                    is_store = 1'b1;
                end
            end
            OPC_LUI, OPC_AUIPC:
            begin
                writes = 1'b1;
                val    = {instr[31:12], 12'd0};
            end
            default:
            begin
                illegal = 1'b1;
            end
        endcase
    end

    // an illegal word never stalls, whatever it reads
    assign stall = !illegal && last_wrote && (last_dest != REG_ZERO)
                   && ((reads1 && rs1 == last_dest) || (reads2 && rs2 == last_dest));
    assign wrote = writes && !illegal && (rd != REG_ZERO);

    always_comb
    begin
        result                    = '0;
        result.reg_written        = wrote;
        result.dest_reg           = wrote ? rd : REG_ZERO;
        result.write_value        = wrote ? val : '0;
        result.store_valid        = is_store;
        result.store_index        = is_store ? sidx : '0;
        result.store_data         = is_store ? op_b : '0;
        result.store_out_of_range = is_store && (sidx >= DMEM_DEPTH);
        result.hazard_stall       = stall;
        result.illegal_instr      = illegal;
    end

endmodule

`default_nettype wire

// ----- rtl/rvx_checker.sv -----
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks of the rv32 integer execute core result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [111:0] m_axis_tdata
);

    // an illegal word neither writes, stores nor stalls
    a_illegal_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[105] |-> !m_axis_tdata[0] && !m_axis_tdata[38]
                                              && !m_axis_tdata[104])
        else $error("illegal instruction with side effect");

    // a write always names a nonzero destination, no write shows zeros
    a_write_dest: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] && m_axis_tdata[5:1] != 5'd0)
                          || (!m_axis_tdata[0] && m_axis_tdata[37:1] == 37'd0))
        else $error("inconsistent register write fields");

    // range flag only on a store
    a_oor_store: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[103] |-> m_axis_tdata[38])
        else $error("out of range flag without store");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind rv32_integer_execute_core rvx_checker u_rvx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rv32_integer_execute_core. Instruction words are
// streamed in (directed corner cases first, then random mixes of well-formed
// and malformed words), and a behavioral model of the register file and
// hazard history predicts each result record. Sender gaps and receiver
// stalls vary by phase, and one long receiver hold-off backs the core up.
// ----------------------------------------------------------------------------

module testbench;
    import rvx_pkg::*;

    // an opcode the core must reject, used in a directed word
    localparam logic [6:0] OPC_LOAD = 7'b0000011;

    localparam int RANDOM_ITEMS = 900;
    localparam int PHASES       = 4;
    localparam int HOLD_CYCLES  = 64;

    // ------------------------------------------------------------------------
    // predicted results and checking
    // ------------------------------------------------------------------------
    class execute_checker;
        logic [31:0]  regs [32];
        logic [4:0]   prev_dest;
        bit           prev_wrote;
        exec_result_t expected_results [$];
        int           mismatch_count;
        int           result_count;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            prev_dest      = REG_ZERO;
            prev_wrote     = 1'b0;
            mismatch_count = 0;
            result_count   = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at result %0d: %s", result_count, what);
            mismatch_count++;
        endtask

        // works out the record for one accepted instruction word
        function void note_instr(logic [31:0] w);
            logic [6:0]   opc;
            logic [6:0]   f7;
            logic [4:0]   rd;
            logic [4:0]   rs1;
            logic [4:0]   rs2;
            logic [2:0]   f3;
            logic [31:0]  a;
            logic [31:0]  b;
            logic [31:0]  imm;
            logic [31:0]  val;
            logic [31:0]  sidx;
            logic [31:0]  sdata;
            bit           illegal;
            bit           writes;
            bit           store;
            bit           reads1;
            bit           reads2;
            bit           stall;
            bit           wrote;
            exec_result_t exp_rec;

            opc = w[6:0];
            rd  = w[11:7];
            f3  = w[14:12];
            rs1 = w[19:15];
            rs2 = w[24:20];
            f7  = w[31:25];
            a   = regs[rs1];
            b   = regs[rs2];
            illegal = 0; writes = 0; store = 0; reads1 = 0; reads2 = 0;
            val = '0; sidx = '0; sdata = '0;
            imm = {{20{w[31]}}, w[31:20]};

            if (opc == OPC_R)
            begin
                reads1 = 1; reads2 = 1; writes = 1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << b[4:0];
                        F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
                        F3_XOR:  val = a ^ b;
                        F3_SR:   val = a >> b[4:0];
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    val = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    val = $signed(a) >>> b[4:0];
                else if (f7 == F7_MUL && f3 == F3_ADD)
                    val = a * b;
                else
                    illegal = 1;
            end
            else if (opc == OPC_I)
            begin
                reads1 = 1; writes = 1;
                case (f3)
                    F3_ADD:  val = a + imm;
                    F3_SLL:  val = a << imm[4:0];
                    F3_SLT:  val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
                    F3_SLTU: val = (a < imm) ? 32'd1 : 32'd0;
                    F3_XOR:  val = a ^ imm;
                    F3_SR:
                    begin
                        // imm bit 10 picks arithmetic, bit 11 must be clear
                        if (w[31:30] == SRI_LOGIC)
                            val = a >> imm[4:0];
                        else if (w[31:30] == SRI_ARITH)
                            val = $signed(a) >>> imm[4:0];
                        else
                            illegal = 1;
                    end
                    F3_OR:   val = a | imm;
                    default: val = a & imm;
                endcase
            end
            else if (opc == OPC_STORE)
            begin
                if (f3 > F3_STORE_MAX)
                    illegal = 1;
                else
                begin
                    imm = {{20{w[31]}}, w[31:25], w[11:7]};
                    reads1 = 1; reads2 = 1; store = 1;
                    sidx  = a + imm;
                    sdata = b;
                end
            end
            else if (opc == OPC_LUI || opc == OPC_AUIPC)
            begin
                // auipc adds no pc here
                writes = 1;
                val = {w[31:12], 12'h000};
            end
            else
                illegal = 1;

            if (illegal)
            begin
                writes = 0; store = 0; reads1 = 0; reads2 = 0;
                val = '0; sidx = '0; sdata = '0;
            end

            stall = prev_wrote && prev_dest != REG_ZERO &&
                    ((reads1 && rs1 == prev_dest) || (reads2 && rs2 == prev_dest));
            wrote = writes && rd != REG_ZERO;
            if (wrote)
                regs[rd] = val;

            exp_rec.reg_written        = wrote;
            exp_rec.dest_reg           = wrote ? rd : REG_ZERO;
            exp_rec.write_value        = wrote ? val : '0;
            exp_rec.store_valid        = store;
            exp_rec.store_index        = sidx;
            exp_rec.store_data         = sdata;
            exp_rec.store_out_of_range = store && (sidx >= DMEM_DEPTH);
            exp_rec.hazard_stall       = stall;
            exp_rec.illegal_instr      = illegal;
            expected_results.insert(expected_results.size(), exp_rec);

            prev_wrote = wrote;
            prev_dest  = wrote ? rd : REG_ZERO;
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        // compares one accepted result record with the oldest prediction
        task check_result(logic [111:0] d);
            exec_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("reg_written", d[0], want.reg_written);
                compare_field("dest_reg", d[5:1], want.dest_reg);
                compare_field("write_value", d[37:6], want.write_value);
                compare_field("store_valid", d[38], want.store_valid);
                compare_field("store_index", d[70:39], want.store_index);
                compare_field("store_data", d[102:71], want.store_data);
                compare_field("store_out_of_range", d[103], want.store_out_of_range);
                compare_field("hazard_stall", d[104], want.hazard_stall);
                compare_field("illegal_instr", d[105], want.illegal_instr);
                compare_field("pad", d[111:106], '0);
            end
            result_count++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals and the core
    // ------------------------------------------------------------------------
    logic         clk;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;   // [31:0] instr_word
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] reg_written, [5:1] dest_reg, [37:6] write_value, [38] store_valid,
    // [70:39] store_index, [102:71] store_data, [103] store_out_of_range,
    // [104] hazard_stall, [105] illegal_instr, [111:106] zero
    logic [111:0] m_axis_tdata;

    execute_checker checker_h = new();

    int          send_idle_pct  = 0;    // chance in a hundred of a sender gap
    int          recv_stall_pct = 0;    // chance in a hundred of a receiver stall
    int          hold_left      = 0;    // cycles of forced receiver hold-off
    logic [4:0]  recent_rd      = '0;   // last destination generated, for hazards

    rv32_integer_execute_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitor: both sides sampled at the edge, before this edge's updates
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                checker_h.note_instr(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                checker_h.check_result(m_axis_tdata);
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // instruction encoders
    // ------------------------------------------------------------------------
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2,
                                          logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_R};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {imm, rs1, f3, rd, OPC_I};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2,
                                          logic [4:0] rs1, logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd,
                                          logic [6:0] opc);
        return {imm, rd, opc};
    endfunction

    // source register, often the destination just generated to provoke stalls
    function automatic logic [4:0] pick_src();
        if ($urandom_range(2) == 0)
            return recent_rd;
        return 5'($urandom_range(31));
    endfunction

    // mostly well-formed words with random content, the rest noise
    function automatic logic [31:0] random_instr();
        int          kind;
        int          sel;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [31:0] w;

        kind = $urandom_range(99);
        rd   = 5'($urandom_range(31));
        rs1  = pick_src();
        rs2  = pick_src();
        f3   = 3'($urandom_range(7));
        imm  = 12'($urandom());
        if (kind < 35)
        begin
            sel = $urandom_range(10);
            if (sel < 8)
                w = enc_r(F7_BASE, rs2, rs1, 3'(sel), rd);
            else if (sel == 8)
                w = enc_r(F7_ALT, rs2, rs1, F3_ADD, rd);
            else if (sel == 9)
                w = enc_r(F7_ALT, rs2, rs1, F3_SR, rd);
            else
                w = enc_r(F7_MUL, rs2, rs1, F3_ADD, rd);
        end
        else if (kind < 60)
        begin
            if (f3 == F3_SR)
                imm[11:10] = $urandom_range(1) ? SRI_ARITH : SRI_LOGIC;
            w = enc_i(imm, rs1, f3, rd);
        end
        else if (kind < 75)
        begin
            // a zero base register keeps the index near the memory depth
            if ($urandom_range(1))
                rs1 = REG_ZERO;
            w = enc_s(imm, rs2, rs1, 3'($urandom_range(F3_STORE_MAX)));
        end
        else if (kind < 85)
        begin
            w = enc_u(20'($urandom()), rd, $urandom_range(1) ? OPC_LUI : OPC_AUIPC);
        end
        else
        begin
            w = $urandom();
            case ($urandom_range(5))
                0: w[6:0] = OPC_R;
                1: w[6:0] = OPC_I;
                2: w[6:0] = OPC_STORE;
                default: ;
            endcase
        end
        recent_rd = w[11:7];
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // sender: optional gaps, then hold the word until the transfer happens
    // ------------------------------------------------------------------------
    task send_instr(logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task send_directed();
        // build extreme operands: x1 top bits, x2 all ones, x4 sign bit only
        send_instr(enc_u(20'hFFFFF, 5'd1, OPC_LUI));
        send_instr(enc_i(12'hFFF, REG_ZERO, F3_ADD, 5'd2));
        send_instr(enc_i(12'h7FF, 5'd2, F3_ADD, 5'd3));
        send_instr(enc_u(20'h80000, 5'd4, OPC_AUIPC));
        // every register-register operation
        send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd5));
        send_instr(enc_r(F7_ALT, 5'd4, 5'd2, F3_ADD, 5'd6));
        send_instr(enc_r(F7_BASE, 5'd3, 5'd4, F3_SLL, 5'd7));
        send_instr(enc_r(F7_BASE, 5'd2, 5'd4, F3_SLT, 5'd8));
        send_instr(enc_r(F7_BASE, 5'd2, 5'd4, F3_SLTU, 5'd9));
        send_instr(enc_r(F7_BASE, 5'd1, 5'd2, F3_XOR, 5'd10));
        send_instr(enc_r(F7_BASE, 5'd2, 5'd4, F3_SR, 5'd11));
        send_instr(enc_r(F7_ALT, 5'd2, 5'd4, F3_SR, 5'd12));
        send_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_OR, 5'd13));
        send_instr(enc_r(F7_BASE, 5'd4, 5'd2, F3_AND, 5'd14));
        send_instr(enc_r(F7_MUL, 5'd4, 5'd2, F3_ADD, 5'd15));
        // every remaining immediate operation, immediates at extremes or bit patterns
        send_instr(enc_i(12'h01F, 5'd2, F3_SLL, 5'd16));
        send_instr(enc_i(12'h800, 5'd4, F3_SLT, 5'd17));
        send_instr(enc_i(12'hFFF, 5'd4, F3_SLTU, 5'd18));
        send_instr(enc_i(12'h800, 5'd1, F3_XOR, 5'd19));
        send_instr(enc_i({SRI_LOGIC, 10'h01F}, 5'd4, F3_SR, 5'd20));
        send_instr(enc_i({SRI_ARITH, 10'h001}, 5'd4, F3_SR, 5'd21));
        send_instr(enc_i(12'h555, 5'd2, F3_OR, 5'd22));
        send_instr(enc_i(12'hAAA, 5'd2, F3_AND, 5'd23));
        // malformed shift immediate, bad funct pair, bad store width, load
        send_instr(enc_i({2'b10, 10'h003}, 5'd4, F3_SR, 5'd24));
        send_instr(enc_r(F7_ALT, 5'd2, 5'd1, F3_SLL, 5'd25));
        send_instr(enc_s(12'h000, 5'd2, REG_ZERO, F3_STORE_MAX + 3'd1));
        send_instr({25'h0, OPC_LOAD});
        // last in-range store index, first out-of-range one, write to x0
        send_instr(enc_s(12'h3FF, 5'd2, REG_ZERO, F3_STORE_MAX));
        send_instr(enc_s(12'h400, 5'd2, REG_ZERO, F3_ADD));
        send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, REG_ZERO));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    // long hold-off while words keep coming: core fills up
                    hold_left = HOLD_CYCLES;
                end
                1:
                begin
                    send_idle_pct = 49; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct = 17; recv_stall_pct = 17;
                end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
                send_instr(random_instr());
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (checker_h.pending() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (8) @(posedge clk);

        if (checker_h.mismatch_count == 0 && checker_h.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
